FILE: src/sact_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the cache tag and replacement engine.
package sact_pkg;

  localparam int OP_W = 4;
  localparam int SET_W = 10;
  localparam int WAY_W = 3;
  localparam int ST_W = 3;

  localparam int SET_COUNT = 1024;
  localparam int ASSOC = 8;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP    = 4'd0,
    OP_TOUCH     = 4'd1,
    OP_VICTIM    = 4'd2,
    OP_SET_BLOCK = 4'd3,
    OP_SET_TRANS = 4'd4,
    OP_GET_BLOCK = 4'd5,
    OP_OR_DIRTY  = 4'd6,
    OP_OR_VALID  = 4'd7,
    OP_CLR_DIRTY = 4'd8,
    OP_CLR_VALID = 4'd9,
    OP_POP_DIRTY = 4'd10
  } opcode_t;

  localparam logic [2:0] POL_LRU = 3'd0;
  localparam logic [2:0] POL_LRU_EXT = 3'd1;
  localparam logic [2:0] POL_LRU_BASE = 3'd2;
  localparam logic [2:0] POL_FIFO = 3'd3;

  localparam logic [0:0] CFG_POLICY = 1'd0;
  localparam logic [0:0] CFG_LINE = 1'd1;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  // Command handed from the front to the back part.
  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [31:0]      address;
    logic [SET_W-1:0] set_index;
    logic [WAY_W-1:0] way_index;
    logic [31:0]      tag_value;
    logic [ST_W-1:0]  new_state;
    logic [31:0]      word_mask;
    logic [7:0]       lock_bits;
  } cmd_t;

  typedef struct packed {
    logic             hit;
    logic [SET_W-1:0] set_out;
    logic [WAY_W-1:0] way_out;
    logic [ST_W-1:0]  state_out;
    logic [31:0]      tag_out;
    logic [31:0]      dirty_out;
    logic [31:0]      dirty_word_address;
  } res_t;

endpackage

FILE: src/sact_front.sv
`timescale 1ns / 1ps
// Front part: accepts commands and queues them for the back part.
module sact_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sact_pkg::cmd_t in_cmd,
  output logic           q_valid,
  input  logic           q_ready,
  output sact_pkg::cmd_t q_cmd
);
  import sact_pkg::*;

  cmd_t       slot [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) slot[wr_ptr] <= in_cmd;
  end

endmodule

FILE: src/sact_back.sv
`timescale 1ns / 1ps
// Back part: clears the arrays, then serves each command by set read-modify-write.
module sact_back #(
  parameter int MASK_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [2:0]     policy,
  input  logic [3:0]     line_log,
  input  logic           q_valid,
  output logic           q_ready,
  input  sact_pkg::cmd_t q_cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output sact_pkg::res_t res
);
  import sact_pkg::*;

  localparam int SI_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WI_W = (ASSOC > 1) ? $clog2(ASSOC) : 1;

  typedef struct packed {
    logic [ASSOC-1:0][31:0]       tag;
    logic [ASSOC-1:0][ST_W-1:0]   st;
    logic [ASSOC-1:0][31:0]       trans;
    logic [ASSOC-1:0][MASK_BITS-1:0] dirty;
    logic [ASSOC-1:0][MASK_BITS-1:0] valid;
    logic [ASSOC-1:0][WI_W-1:0]   order;
  } set_row_t;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  set_row_t mem [SET_COUNT];
  set_row_t rd_row;
  set_row_t wr_row;
  set_row_t reset_row;
  state_t   state;
  logic [SI_W-1:0] clr_idx;
  logic [SI_W-1:0] cur_set;
  cmd_t     cmd;
  logic [31:0] lfsr;
  logic [31:0] lfsr_step;
  logic     lfsr_adv;
  res_t     res_next;
  logic     full;

  function automatic logic [SI_W-1:0] set_of(input logic [31:0] v);
    return v[SI_W-1:0];
  endfunction

  always_comb begin
    reset_row = '0;
    for (int i = 0; i < ASSOC; i++) reset_row.order[i] = WI_W'(i);
  end

  always_comb begin
    lfsr_step = {1'b0, lfsr[31:1]};
    if (lfsr[0]) lfsr_step = lfsr_step ^ LFSR_TAPS;
  end

  // Move way w to the head of the recency order.
  function automatic logic [ASSOC-1:0][WI_W-1:0] to_head(
    input logic [ASSOC-1:0][WI_W-1:0] o, input logic [WI_W-1:0] w);
    logic [ASSOC-1:0][WI_W-1:0] n;
    logic seen;
    n = o;
    seen = 1'b0;
    for (int p = 0; p < ASSOC; p++) begin
      if (!seen && o[p] == w) seen = 1'b1;
    end
    if (seen) begin
      seen = 1'b0;
      n[0] = w;
      for (int p = 1; p < ASSOC; p++) begin
        if (o[p-1] == w) seen = 1'b1;
        n[p] = seen ? o[p] : o[p-1];
      end
    end
    return n;
  endfunction

  always_comb begin
    logic [31:0] ltag;
    logic [31:0] lmask;
    logic        found;
    logic [WI_W-1:0] w;
    logic [WI_W-1:0] c;
    logic [ST_W-1:0] wst;
    logic [MASK_BITS-1:0] dm;
    logic [MASK_BITS-1:0] wm;
    logic        report;
    logic        way_ok;
    logic [5:0]  k;
    wr_row = rd_row;
    res_next = '0;
    res_next.dirty_word_address = ALL_ONES;
    lfsr_adv = 1'b0;
    lmask = (32'd1 << line_log) - 32'd1;
    ltag = cmd.address & ~lmask;
    found = 1'b0;
    report = 1'b0;
    c = '0;
    wst = '0;
    dm = '0;
    w = cmd.way_index[WI_W-1:0];
    way_ok = ({29'd0, cmd.way_index} < 32'(ASSOC));
    wm = cmd.word_mask[MASK_BITS-1:0];
    k = '0;
    unique case (cmd.opcode)
      OP_LOOKUP: begin
        res_next.set_out = SET_W'(cur_set);
        for (int i = 0; i < ASSOC; i++) begin
          if (!found && rd_row.st[i] != '0 && rd_row.tag[i] == ltag) begin
            found = 1'b1;
            res_next.hit = 1'b1;
            res_next.way_out = WAY_W'(i);
            res_next.state_out = rd_row.st[i];
            res_next.tag_out = rd_row.tag[i];
            res_next.dirty_out = 32'(rd_row.dirty[i]);
          end
        end
      end
      OP_VICTIM: begin
        report = 1'b1;
        for (int p = ASSOC - 1; p >= 0; p--) begin
          c = rd_row.order[p];
          if (!found && rd_row.st[c] == '0 && rd_row.trans[c] == '0) begin
            found = 1'b1;
            w = c;
          end
        end
        if (found) begin
          wr_row.order = to_head(rd_row.order, w);
        end else begin
          w = rd_row.order[ASSOC-1];
          priority case (policy)
            POL_LRU, POL_FIFO: wr_row.order = to_head(rd_row.order, w);
            POL_LRU_BASE: ;
            POL_LRU_EXT: begin
              for (int p = ASSOC - 1; p >= 0; p--) begin
                c = rd_row.order[p];
                if (!found && !cmd.lock_bits[3'(c)]) begin
                  found = 1'b1;
                  w = c;
                end
              end
              wr_row.order = to_head(rd_row.order, w);
            end
            default: begin
              lfsr_adv = 1'b1;
              w = WI_W'(lfsr_step % 32'(ASSOC));
            end
          endcase
        end
      end
      default: begin
        if (cmd.opcode <= OP_POP_DIRTY && way_ok) begin
          report = 1'b1;
          unique case (cmd.opcode)
            OP_TOUCH: begin
              if (policy <= POL_LRU_BASE ||
                  (policy == POL_FIFO && rd_row.st[w] == '0))
                wr_row.order = to_head(rd_row.order, w);
            end
            OP_SET_BLOCK: begin
              if (policy == POL_FIFO && rd_row.tag[w] != cmd.tag_value)
                wr_row.order = to_head(rd_row.order, w);
              if (cmd.tag_value == rd_row.trans[w]) wr_row.trans[w] = ALL_ONES;
              wr_row.tag[w] = cmd.tag_value;
              wr_row.st[w] = cmd.new_state;
              wr_row.dirty[w] = '0;
              wr_row.valid[w] = '0;
            end
            OP_SET_TRANS: wr_row.trans[w] = cmd.tag_value;
            OP_OR_DIRTY: wr_row.dirty[w] = rd_row.dirty[w] | wm;
            OP_OR_VALID: wr_row.valid[w] = rd_row.valid[w] | wm;
            OP_CLR_DIRTY: wr_row.dirty[w] = '0;
            OP_CLR_VALID: wr_row.valid[w] = '0;
            OP_POP_DIRTY: begin
              dm = rd_row.dirty[w];
              if (rd_row.st[w] != '0 && dm != '0) begin
                for (int i = MASK_BITS - 1; i >= 0; i--) begin
                  if (dm[i]) k = 6'(i);
                end
                res_next.dirty_word_address = rd_row.tag[w] + {24'd0, k, 2'b00};
                dm[k[4:0]] = 1'b0;
                wr_row.dirty[w] = dm;
              end
            end
            default: ;
          endcase
        end
      end
    endcase
    if (report) begin
      wst = wr_row.st[w];
      res_next.set_out = SET_W'(cur_set);
      res_next.way_out = WAY_W'(w);
      res_next.state_out = wst;
      res_next.tag_out = wr_row.tag[w];
      res_next.dirty_out = 32'(wr_row.dirty[w]);
    end
  end

  assign q_ready = (state == S_IDLE) && !full;
  assign res_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      full <= 1'b0;
      lfsr <= 32'd1;
    end else begin
      if (full && res_ready) full <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (32'(clr_idx) == 32'(SET_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: if (q_valid && !full) state <= S_READ;
        S_READ: state <= S_WRITE;
        S_WRITE: begin
          state <= S_IDLE;
          full <= 1'b1;
          if (cmd.opcode == OP_VICTIM && lfsr_adv) lfsr <= lfsr_step;
        end
        default: state <= S_CLEAR;
      endcase
    end
    if (state == S_IDLE && q_valid && !full) begin
      cmd <= q_cmd;
      if (q_cmd.opcode == OP_LOOKUP) cur_set <= set_of(q_cmd.address >> line_log);
      else cur_set <= set_of({22'd0, q_cmd.set_index});
    end
    if (state == S_READ) rd_row <= mem[cur_set];
    if (state == S_CLEAR) mem[clr_idx] <= reset_row;
    else if (state == S_WRITE) mem[cur_set] <= wr_row;
    if (state == S_WRITE) res <= res_next;
  end

endmodule

FILE: src/set_assoc_cache_tag_replacement.sv
`timescale 1ns / 1ps
// Top level of the cache tag and replacement engine.
// Usage:
//  s_axis carries one command word; m_axis returns one result word per command.
//  cfg writes replacement_policy (index 0) or log_line_bytes (index 1); write only while idle (not enforced).
//  A two-entry queue decouples command intake from execution.
//  Each command holds the back part through queue pop, set read, set write and
//  result handoff, set by the read-modify-write of the single-port set memory,
//  so the back part takes no new command until the last result is handed off.
//  A result becomes valid once its command has passed pop, set read and set write.
//  After reset a clearing pass over all SET_COUNT (1024) sets initializes the set
//  memory; commands queue (two deep) but are not served until it ends.
//  When m_axis_tready is low the result is held and the next command waits
//  in the queue; the front keeps accepting until the queue is full.
module set_assoc_cache_tag_replacement #(
  parameter int MASK_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[3:0], address[35:4], set_index[45:36], way_index[48:46],
  // tag_value[80:49], new_state[83:81], word_mask[115:84], lock_bits[123:116]
  input  logic [127:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // hit[0], set_out[10:1], way_out[13:11], state_out[16:14], tag_out[48:17],
  // dirty_out[80:49], dirty_word_address[112:81]
  output logic [119:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import sact_pkg::*;

  cmd_t in_cmd;
  cmd_t q_cmd;
  res_t res;
  logic q_valid;
  logic q_ready;
  logic [2:0] policy;
  logic [3:0] line_log;

  assign in_cmd = '{opcode: s_axis_tdata[3:0], address: s_axis_tdata[35:4],
                    set_index: s_axis_tdata[45:36], way_index: s_axis_tdata[48:46],
                    tag_value: s_axis_tdata[80:49], new_state: s_axis_tdata[83:81],
                    word_mask: s_axis_tdata[115:84], lock_bits: s_axis_tdata[123:116]};

  assign m_axis_tdata = {7'd0, res.dirty_word_address, res.dirty_out, res.tag_out,
                         res.state_out, res.way_out, res.set_out, res.hit};

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_LRU;
      line_log <= 4'd6;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_POLICY) policy <= cfg_data[2:0];
      else if (cfg_index == CFG_LINE) line_log <= cfg_data[3:0];
    end
  end

  sact_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  sact_back #(.MASK_BITS(MASK_BITS)) u_back (
    .clk(clk), .rst(rst), .policy(policy), .line_log(line_log),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
  );

endmodule

FILE: src/sact_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the cache tag engine, bound to the top level.
module sact_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result after reset");
  a_ready_after_reset: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("queue not empty after reset");
  a_hit_state: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[16:14] != 3'd0)
    else $error("hit on invalid line");
endmodule

bind set_assoc_cache_tag_replacement sact_checker u_checker (
  .clk(clk), .rst(rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
